>>> src/tcvs_pkg.sv
// shared constants, register indexes and helpers of the two-center verlet stepper
package tcvs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_ONE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_TWO_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_TOL = 3'd5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [16:0]        RST_TIME_STEP  = 17'd655;
    localparam logic [30:0]        RST_MASS       = 31'd655360;
    localparam logic signed [31:0] RST_MASS_ONE_X = -32'sd65536;
    localparam logic signed [31:0] RST_MASS_TWO_X = 32'sd65536;
    localparam logic [30:0]        RST_ENERGY_TOL = 31'd32768;

    localparam logic [61:0] DIV_CAP = {1'b1, 61'b0};
    localparam logic [30:0] G_MAX   = 31'h7fff_ffff;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            res = 32'sh7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? 32'(-v) : 32'(v);
        return res;
    endfunction

endpackage

>>> src/two_center_verlet_step.sv
// velocity verlet stepper for one particle pulled by two fixed masses
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata x,y,vx,vy; tuser action
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata x,y,step; tuser collided
//  cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// one shared subtract/compare unit runs every square root and every division;
// one shared multiplier feeds it
// synchronous active-low reset restores register defaults and sets the halt flag
// s_axis is not ready while an item is in work; a result waits in the output register
module two_center_verlet_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [127:0]                      s_axis_tdata,  // start_x, start_y, start_vx, start_vy
    input  logic [0:0]                        s_axis_tuser,  // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [95:0]                       m_axis_tdata,  // pos_out_x, pos_out_y, step_number
    output logic [0:0]                        m_axis_tuser,  // collided
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcvs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcvs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tcvs_pkg::*;

    localparam int DIV_MAX = 32 + 2 * FRAC_BITS;
    localparam int CNT_W   = $clog2(DIV_MAX);
    localparam int U_W     = FRAC_BITS + 1;
    localparam int DT2_W   = 33 - FRAC_BITS;
    localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_ONE  = CNT_W'(32 + FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_TWO  = CNT_W'(DIV_MAX - 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_KE1   = 5'd1;
    localparam logic [4:0] S_KE2   = 5'd2;
    localparam logic [4:0] S_KE3   = 5'd3;
    localparam logic [4:0] S_GDX   = 5'd4;
    localparam logic [4:0] S_GM1   = 5'd5;
    localparam logic [4:0] S_GM2   = 5'd6;
    localparam logic [4:0] S_GR2   = 5'd7;
    localparam logic [4:0] S_SQ    = 5'd8;
    localparam logic [4:0] S_DIVP  = 5'd9;
    localparam logic [4:0] S_DIVG  = 5'd10;
    localparam logic [4:0] S_DIVUX = 5'd11;
    localparam logic [4:0] S_MULX  = 5'd12;
    localparam logic [4:0] S_ADDX  = 5'd13;
    localparam logic [4:0] S_DIVUY = 5'd14;
    localparam logic [4:0] S_MULY  = 5'd15;
    localparam logic [4:0] S_ADDY  = 5'd16;
    localparam logic [4:0] S_NEXT  = 5'd17;
    localparam logic [4:0] S_DT1   = 5'd18;
    localparam logic [4:0] S_DT2   = 5'd19;
    localparam logic [4:0] S_PX1   = 5'd20;
    localparam logic [4:0] S_PX2   = 5'd21;
    localparam logic [4:0] S_PY1   = 5'd22;
    localparam logic [4:0] S_PY2   = 5'd23;
    localparam logic [4:0] S_V1    = 5'd24;
    localparam logic [4:0] S_V2    = 5'd25;
    localparam logic [4:0] S_V3    = 5'd26;
    localparam logic [4:0] S_EMIT  = 5'd27;

    localparam logic [1:0] PH_LOAD_EN  = 2'd0;
    localparam logic [1:0] PH_LOAD_ACC = 2'd1;
    localparam logic [1:0] PH_STEP_EN  = 2'd2;
    localparam logic [1:0] PH_STEP_ACC = 2'd3;

    // configuration
    logic [16:0]        r_dt;
    logic [30:0]        r_m1, r_m2, r_tol;
    logic signed [31:0] r_m1x, r_m2x;

    // particle state
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay, r_e0;
    logic               r_halted;
    logic [31:0]        r_step_cnt;

    // sequencer and datapath
    logic [4:0]         r_state, n_state;
    logic [1:0]         r_phase;
    logic               r_mk;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc, r_r2;
    logic signed [63:0] r_esum;
    logic signed [31:0] r_dx;
    logic [31:0]        r_r;
    logic [30:0]        r_g;
    logic [U_W-1:0]     r_u;
    logic signed [33:0] r_sx, r_sy;
    logic [DT2_W-1:0]   r_dt2;
    logic signed [63:0] r_t;
    logic [CNT_W-1:0]   r_cnt;
    logic [63:0]        r_rem, r_sres, r_den;
    logic [31:0]        r_num;
    logic [61:0]        r_q;
    logic               r_coll;

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_ox, r_oy;
    logic [31:0]        r_ostep;
    logic               r_ocoll;

    logic               in_fire, acc_mode, div_run, emit_go, last_it;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [64:0]        sub_a, sub_b;
    logic [65:0]        sub_d;
    logic               sub_ge;
    logic [63:0]        sbit, sres_n;
    logic [64:0]        rem_s;
    logic [62:0]        q_s;
    logic [61:0]        q_n;
    logic signed [31:0] mx_sel;
    logic [30:0]        m_sel;
    logic signed [31:0] sat_sx, sat_sy, e_now;
    logic signed [32:0] drift;
    logic [32:0]        drift_mag;
    logic               collide;
    logic               st_go, st_two;
    logic [31:0]        st_num;
    logic [63:0]        st_den;
    logic [30:0]        term;
    logic [63:0]        r2_sum;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign acc_mode = (r_phase == PH_LOAD_ACC) || (r_phase == PH_STEP_ACC);
    assign div_run  = (r_state == S_DIVP) || (r_state == S_DIVG) ||
                      (r_state == S_DIVUX) || (r_state == S_DIVUY);
    assign emit_go  = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);
    assign last_it  = (r_cnt == '0);
    assign mx_sel   = r_mk ? r_m2x : r_m1x;
    assign m_sel    = r_mk ? r_m2 : r_m1;
    assign sat_sx   = sat32({{30{r_sx[33]}}, r_sx});
    assign sat_sy   = sat32({{30{r_sy[33]}}, r_sy});
    assign e_now    = sat32(r_esum);
    assign drift    = {e_now[31], e_now} - {r_e0[31], r_e0};
    assign drift_mag = drift[32] ? 33'(-drift) : 33'(drift);
    assign collide  = drift_mag > {2'b0, r_tol};
    assign term     = r_prod[FRAC_BITS+30:FRAC_BITS];
    assign r2_sum   = r_acc + 64'(r_prod);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_KE1: begin
                mul_a = {{2{r_vx[31]}}, r_vx};
                mul_b = {{2{r_vx[31]}}, r_vx};
            end
            S_KE2: begin
                mul_a = {{2{r_vy[31]}}, r_vy};
                mul_b = {{2{r_vy[31]}}, r_vy};
            end
            S_GM1: begin
                mul_a = {{2{r_dx[31]}}, r_dx};
                mul_b = {{2{r_dx[31]}}, r_dx};
            end
            S_GM2: begin
                mul_a = {{2{r_py[31]}}, r_py};
                mul_b = {{2{r_py[31]}}, r_py};
            end
            S_MULX, S_MULY: begin
                mul_a = {3'b0, r_g};
                mul_b = 34'(r_u);
            end
            S_DT1: begin
                mul_a = {17'b0, r_dt};
                mul_b = {17'b0, r_dt};
            end
            S_DT2: begin
                mul_a = {{2{r_vx[31]}}, r_vx};
                mul_b = {17'b0, r_dt};
            end
            S_PX1: begin
                mul_a = {{2{r_ax[31]}}, r_ax};
                mul_b = 34'(r_dt2);
            end
            S_PX2: begin
                mul_a = {{2{r_vy[31]}}, r_vy};
                mul_b = {17'b0, r_dt};
            end
            S_PY1: begin
                mul_a = {{2{r_ay[31]}}, r_ay};
                mul_b = 34'(r_dt2);
            end
            S_V1: begin
                mul_a = {{2{r_ax[31]}}, r_ax} + {{2{sat_sx[31]}}, sat_sx};
                mul_b = {17'b0, r_dt};
            end
            S_V2: begin
                mul_a = {{2{r_ay[31]}}, r_ay} + {{2{sat_sy[31]}}, sat_sy};
                mul_b = {17'b0, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // shared subtract and compare unit for square root and division
    assign sbit  = 64'(1) << {r_cnt[4:0], 1'b0};
    assign rem_s = {r_rem, r_num[31]};
    always_comb begin
        if (r_state == S_SQ) begin
            sub_a = {1'b0, r_rem};
            sub_b = {1'b0, r_sres} + {1'b0, sbit};
        end else begin
            sub_a = rem_s;
            sub_b = {1'b0, r_den};
        end
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[65];
    assign sres_n = sub_ge ? (r_sres >> 1) + sbit : (r_sres >> 1);
    assign q_s    = {r_q, sub_ge};
    assign q_n    = (q_s > {1'b0, DIV_CAP}) ? DIV_CAP : q_s[61:0];

    // division launch
    always_comb begin
        st_go  = 1'b0;
        st_two = 1'b0;
        st_num = '0;
        st_den = '0;
        case (r_state)
            S_SQ: begin
                st_go  = last_it && (!acc_mode || (r_r2 != '0));
                st_two = acc_mode;
                st_num = {1'b0, m_sel};
                st_den = acc_mode ? r_r2 : sres_n;
            end
            S_DIVG: begin
                st_go  = last_it;
                st_num = mag32(r_dx);
                st_den = {32'b0, r_r};
            end
            S_ADDX: begin
                st_go  = 1'b1;
                st_num = mag32(r_py);
                st_den = {32'b0, r_r};
            end
            default: begin
                st_go = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser[0] == ACT_LOAD) begin
                        n_state = S_GDX;
                    end else if (!r_halted) begin
                        n_state = S_KE1;
                    end
                end
            end
            S_KE1:   n_state = S_KE2;
            S_KE2:   n_state = S_KE3;
            S_KE3:   n_state = S_GDX;
            S_GDX:   n_state = S_GM1;
            S_GM1:   n_state = S_GM2;
            S_GM2:   n_state = S_GR2;
            S_GR2:   n_state = S_SQ;
            S_SQ: begin
                if (last_it) begin
                    if (!acc_mode) begin
                        n_state = S_DIVP;
                    end else if (r_r2 == '0) begin
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_DIVG;
                    end
                end
            end
            S_DIVP:  n_state = last_it ? S_NEXT : S_DIVP;
            S_DIVG:  n_state = last_it ? S_DIVUX : S_DIVG;
            S_DIVUX: n_state = last_it ? S_MULX : S_DIVUX;
            S_MULX:  n_state = S_ADDX;
            S_ADDX:  n_state = S_DIVUY;
            S_DIVUY: n_state = last_it ? S_MULY : S_DIVUY;
            S_MULY:  n_state = S_ADDY;
            S_ADDY:  n_state = S_NEXT;
            S_NEXT: begin
                if (!r_mk) begin
                    n_state = S_GDX;
                end else begin
                    unique case (r_phase)
                        PH_LOAD_ACC: n_state = S_KE1;
                        PH_LOAD_EN:  n_state = S_IDLE;
                        PH_STEP_EN:  n_state = collide ? S_EMIT : S_DT1;
                        PH_STEP_ACC: n_state = S_V1;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_DT1:   n_state = S_DT2;
            S_DT2:   n_state = S_PX1;
            S_PX1:   n_state = S_PX2;
            S_PX2:   n_state = S_PY1;
            S_PY1:   n_state = S_PY2;
            S_PY2:   n_state = S_GDX;
            S_V1:    n_state = S_V2;
            S_V2:    n_state = S_V3;
            S_V3:    n_state = S_EMIT;
            S_EMIT:  n_state = emit_go ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_halted   <= 1'b1;
            r_step_cnt <= '0;
            r_ovalid   <= 1'b0;
            r_dt       <= RST_TIME_STEP;
            r_m1       <= RST_MASS;
            r_m2       <= RST_MASS;
            r_m1x      <= RST_MASS_ONE_X;
            r_m2x      <= RST_MASS_TWO_X;
            r_tol      <= RST_ENERGY_TOL;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TIME_STEP:  r_dt  <= i_cfg_data[16:0];
                    CFG_MASS_ONE:   r_m1  <= i_cfg_data[30:0];
                    CFG_MASS_TWO:   r_m2  <= i_cfg_data[30:0];
                    CFG_MASS_ONE_X: r_m1x <= i_cfg_data;
                    CFG_MASS_TWO_X: r_m2x <= i_cfg_data;
                    CFG_ENERGY_TOL: r_tol <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_fire && (s_axis_tuser[0] == ACT_STEP) && !r_halted) begin
                r_step_cnt <= r_step_cnt + 32'd1;
            end
            if ((r_state == S_NEXT) && r_mk) begin
                if (r_phase == PH_LOAD_EN) begin
                    r_halted   <= 1'b0;
                    r_step_cnt <= '0;
                end else if ((r_phase == PH_STEP_EN) && collide) begin
                    r_halted <= 1'b1;
                end
            end
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= signed'(mul_p[63:0]);

        if (div_run || (r_state == S_SQ)) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (r_state == S_SQ) begin
            r_sres <= sres_n;
            if (sub_ge) begin
                r_rem <= sub_d[63:0];
            end
            if (last_it) begin
                r_r <= sres_n[31:0];
            end
        end
        if (div_run) begin
            r_rem <= sub_ge ? sub_d[63:0] : rem_s[63:0];
            r_q   <= q_n;
            r_num <= {r_num[30:0], 1'b0};
        end
        if (st_go) begin
            r_num <= st_num;
            r_den <= st_den;
            r_rem <= '0;
            r_q   <= (st_den == '0) ? DIV_CAP : '0;
            r_cnt <= st_two ? DIV_TWO : DIV_ONE;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_mk <= 1'b0;
                    r_sx <= '0;
                    r_sy <= '0;
                    if (s_axis_tuser[0] == ACT_LOAD) begin
                        r_px    <= s_axis_tdata[31:0];
                        r_py    <= s_axis_tdata[63:32];
                        r_vx    <= s_axis_tdata[95:64];
                        r_vy    <= s_axis_tdata[127:96];
                        r_phase <= PH_LOAD_ACC;
                    end else begin
                        r_phase <= PH_STEP_EN;
                    end
                end
            end
            S_KE2: r_acc <= 64'(r_prod);
            S_KE3: begin
                r_esum <= signed'(r2_sum >> (FRAC_BITS + 1));
                r_mk   <= 1'b0;
            end
            S_GDX: r_dx <= sat32(64'(signed'({r_px[31], r_px} - {mx_sel[31], mx_sel})));
            S_GM2: r_acc <= 64'(r_prod);
            S_GR2: begin
                r_r2   <= r2_sum;
                r_rem  <= r2_sum;
                r_sres <= '0;
                r_cnt  <= SQ_LAST;
            end
            S_DIVP: begin
                if (last_it) begin
                    r_esum <= r_esum - signed'({2'b0, q_n});
                end
            end
            S_DIVG: begin
                if (last_it) begin
                    r_g <= (q_n > {31'b0, G_MAX}) ? G_MAX : q_n[30:0];
                end
            end
            S_DIVUX: begin
                if (last_it) begin
                    r_u <= q_n[U_W-1:0];
                end
            end
            S_DIVUY: begin
                if (last_it) begin
                    r_u <= q_n[U_W-1:0];
                end
            end
            S_ADDX: r_sx <= r_dx[31] ? r_sx + {3'b0, term} : r_sx - {3'b0, term};
            S_ADDY: r_sy <= r_py[31] ? r_sy + {3'b0, term} : r_sy - {3'b0, term};
            S_NEXT: begin
                if (!r_mk) begin
                    r_mk <= 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_LOAD_ACC: begin
                            r_ax    <= sat_sx;
                            r_ay    <= sat_sy;
                            r_phase <= PH_LOAD_EN;
                        end
                        PH_LOAD_EN: r_e0 <= e_now;
                        PH_STEP_EN: r_coll <= collide;
                        PH_STEP_ACC: ;
                        default: ;
                    endcase
                end
            end
            S_DT2: r_dt2 <= r_prod[FRAC_BITS+DT2_W-1:FRAC_BITS];
            S_PX1: r_t <= r_prod >>> FRAC_BITS;
            S_PX2: r_px <= sat32(signed'({{32{r_px[31]}}, r_px}) + r_t +
                                 (r_prod >>> (FRAC_BITS + 1)));
            S_PY1: r_t <= r_prod >>> FRAC_BITS;
            S_PY2: begin
                r_py    <= sat32(signed'({{32{r_py[31]}}, r_py}) + r_t +
                                 (r_prod >>> (FRAC_BITS + 1)));
                r_phase <= PH_STEP_ACC;
                r_mk    <= 1'b0;
                r_sx    <= '0;
                r_sy    <= '0;
            end
            S_V2: r_vx <= sat32(signed'({{32{r_vx[31]}}, r_vx}) + (r_prod >>> (FRAC_BITS + 1)));
            S_V3: begin
                r_vy <= sat32(signed'({{32{r_vy[31]}}, r_vy}) + (r_prod >>> (FRAC_BITS + 1)));
                r_ax <= sat_sx;
                r_ay <= sat_sy;
            end
            default: ;
        endcase

        if (emit_go) begin
            r_ox    <= r_px;
            r_oy    <= r_py;
            r_ostep <= r_step_cnt;
            r_ocoll <= r_coll && (r_phase == PH_STEP_EN);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ostep, r_oy, r_ox};
    assign m_axis_tuser  = r_ocoll;

`ifndef ASSERT_OFF
    a_halt_after_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && (r_phase == PH_STEP_EN)) |=> r_halted)
        else $error("collision result without halt");

    a_halted_step_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (s_axis_tuser[0] == ACT_STEP) && r_halted)
        |=> ($stable(r_step_cnt) && (r_state == S_IDLE)))
        else $error("step while halted changed state");

    a_emit_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> m_axis_tvalid)
        else $error("emitted result not presented");
`endif

endmodule

>>> bench/tb.sv
// testbench for the two-center verlet stepper: directed and random loads and steps, scoreboarded
module tb;
    import tcvs_pkg::*;

    localparam int F          = 16;
    localparam int MAX_CYCLES = 4_000_000;
    localparam int SETTLE     = 1500;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        collided;
        logic [31:0] step_no;
    } t_sample;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // start_x, start_y, start_vx, start_vy
    logic [0:0]   s_axis_tuser = '0;   // action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;        // pos_out_x, pos_out_y, step_number
    logic [0:0]   m_axis_tuser;        // collided
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    two_center_verlet_step dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state and configuration
    longint dt_r, m1_r, m2_r, m1x_r, m2x_r, tol_r;
    longint px, py, vx, vy, ax, ay, e0;
    bit     stopped;
    logic [31:0] steps_done;

    t_sample     expected_q[$];
    int          fails = 0;
    int          cycles = 0;
    int          send_idle = 0;
    int          recv_idle = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root = 0, probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned capped_div(longint unsigned num, int sh,
                                                  longint unsigned den);
        logic [127:0] wide, q;
        if (den == 0) return 64'(DIV_CAP);
        wide = {64'd0, num} << sh;
        q = wide / den;
        if (q > 128'(DIV_CAP)) return 64'(DIV_CAP);
        return q[63:0];
    endfunction

    function automatic longint unsigned dist_sq(longint x, longint y, longint mx,
                                                output longint dx);
        dx = clip32(x - mx);
        return longint'(dx * dx) + longint'(y * y);
    endfunction

    function automatic longint total_energy(longint x, longint y, longint u, longint w);
        longint unsigned kin, r1, r2;
        longint dx;
        kin = (longint'(u * u) + longint'(w * w)) >> (F + 1);
        r1 = int_sqrt(dist_sq(x, y, m1x_r, dx));
        r2 = int_sqrt(dist_sq(x, y, m2x_r, dx));
        return clip32(longint'(kin) - longint'(capped_div(m1_r, F, r1))
                      - longint'(capped_div(m2_r, F, r2)));
    endfunction

    function automatic longint axis_pull(longint unsigned g, longint d, longint unsigned r);
        longint unsigned mag, u, prod;
        longint t;
        mag = (d < 0) ? longint'(-d) : d;
        u = capped_div(mag, F, r);
        prod = g * u;
        t = longint'(prod >> F);
        return (d < 0) ? t : -t;
    endfunction

    task automatic gravity(longint x, longint y, output longint gx, output longint gy);
        longint sx = 0, sy = 0, dx, m, mx;
        longint unsigned d2, r, g;
        for (int k = 0; k < 2; k++) begin
            m  = k ? m2_r : m1_r;
            mx = k ? m2x_r : m1x_r;
            d2 = dist_sq(x, y, mx, dx);
            if (d2 != 0) begin
                r = int_sqrt(d2);
                g = capped_div(m, 2 * F, d2);
                if (g > 64'(G_MAX)) g = 64'(G_MAX);
                sx += axis_pull(g, dx, r);
                sy += axis_pull(g, y, r);
            end
        end
        gx = clip32(sx);
        gy = clip32(sy);
    endtask

    task automatic predict_item(logic act, logic [127:0] d);
        longint e, drift, dt2, nax, nay;
        t_sample s;
        if (act == ACT_LOAD) begin
            px = longint'(signed'(d[31:0]));
            py = longint'(signed'(d[63:32]));
            vx = longint'(signed'(d[95:64]));
            vy = longint'(signed'(d[127:96]));
            gravity(px, py, ax, ay);
            e0 = total_energy(px, py, vx, vy);
            stopped = 0;
            steps_done = 0;
            return;
        end
        if (stopped) return;
        steps_done++;
        e = total_energy(px, py, vx, vy);
        drift = e - e0;
        if (drift < 0) drift = -drift;
        if (drift > tol_r) begin
            stopped = 1;
            s = '{px[31:0], py[31:0], 1'b1, steps_done};
        end else begin
            dt2 = (dt_r * dt_r) >> F;
            px = clip32(px + ((vx * dt_r) >>> F) + ((ax * dt2) >>> (F + 1)));
            py = clip32(py + ((vy * dt_r) >>> F) + ((ay * dt2) >>> (F + 1)));
            gravity(px, py, nax, nay);
            vx = clip32(vx + ((dt_r * (ax + nax)) >>> (F + 1)));
            vy = clip32(vy + ((dt_r * (ay + nay)) >>> (F + 1)));
            ax = nax;
            ay = nay;
            s = '{px[31:0], py[31:0], 1'b0, steps_done};
        end
        expected_q.push_back(s);
    endtask

    // output side
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(negedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result beat x=%h y=%h", m_axis_tdata[31:0],
                       m_axis_tdata[63:32]);
                fails++;
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== want.x) begin
                    $error("pos_out_x expected %h got %h", want.x, m_axis_tdata[31:0]);
                    fails++;
                end
                if (m_axis_tdata[63:32] !== want.y) begin
                    $error("pos_out_y expected %h got %h", want.y, m_axis_tdata[63:32]);
                    fails++;
                end
                if (m_axis_tdata[95:64] !== want.step_no) begin
                    $error("step_number expected %0d got %0d", want.step_no,
                           m_axis_tdata[95:64]);
                    fails++;
                end
                if (m_axis_tuser[0] !== want.collided) begin
                    $error("collided expected %b got %b", want.collided, m_axis_tuser[0]);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [31:0] x, logic [31:0] y,
                             logic [31:0] u, logic [31:0] w);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {w, u, y, x};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        predict_item(act, {w, u, y, x});
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            CFG_TIME_STEP:  dt_r  = val[16:0];
            CFG_MASS_ONE:   m1_r  = val[30:0];
            CFG_MASS_TWO:   m2_r  = val[30:0];
            CFG_MASS_ONE_X: m1x_r = longint'(signed'(val));
            CFG_MASS_TWO_X: m2x_r = longint'(signed'(val));
            CFG_ENERGY_TOL: tol_r = val[30:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle_then_config(logic [31:0] t, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] ax1, logic [31:0] ax2, logic [31:0] tol);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        cfg_write(CFG_TIME_STEP, t);
        cfg_write(CFG_MASS_ONE, a);
        cfg_write(CFG_MASS_TWO, b);
        cfg_write(CFG_MASS_ONE_X, ax1);
        cfg_write(CFG_MASS_TWO_X, ax2);
        cfg_write(CFG_ENERGY_TOL, tol);
    endtask

    task automatic step_n(int n);
        repeat (n) send_item(ACT_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_halted_after_reset();
        step_n(2);
    endtask

    task automatic test_directed();
        send_item(ACT_LOAD, 32'h0000_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000);
        step_n(4);
        // particle sitting on the first mass
        send_item(ACT_LOAD, 32'hffff_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        step_n(2);
        send_item(ACT_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        step_n(2);
        send_item(ACT_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        step_n(2);
        send_item(ACT_LOAD, 32'h0, 32'h0, 32'h0, 32'h0);
        step_n(3);
    endtask

    task automatic test_random(int n);
        int sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                send_item(ACT_LOAD, 32'($signed($urandom_range(524288)) - 262144),
                          32'($signed($urandom_range(524288)) - 262144),
                          32'($signed($urandom_range(131072)) - 65536),
                          32'($signed($urandom_range(131072)) - 65536));
                sent++;
                for (int k = $urandom_range(15, 4); k > 0; k--) begin
                    step_n(1);
                    sent++;
                end
            end else if ($urandom_range(1)) begin
                send_item(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
                step_n(2);
                sent += 3;
            end else begin
                step_n(1);
                sent++;
            end
            if (sent > n / 2 && sent < n / 2 + 12) drain();
        end
    endtask

    initial begin
        dt_r = RST_TIME_STEP; m1_r = RST_MASS; m2_r = RST_MASS;
        m1x_r = RST_MASS_ONE_X; m2x_r = RST_MASS_TWO_X; tol_r = RST_ENERGY_TOL;
        px = 0; py = 0; vx = 0; vy = 0; ax = 0; ay = 0; e0 = 0;
        stopped = 1;
        steps_done = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 33;
        recv_idle = 83;
        test_halted_after_reset();
        test_directed();
        test_random(250);

        settle_then_config(32'd65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                           32'h7fff_ffff, 32'd0);
        test_random(80);

        send_idle = 83;
        recv_idle = 33;
        settle_then_config(32'd1, 32'd0, 32'd0, 32'hfffe_0000, 32'h0002_0000,
                           32'h7fff_ffff);
        test_random(150);

        send_idle = 0;
        recv_idle = 0;
        settle_then_config(32'($urandom_range(2000, 100)), 32'($urandom_range(2000000)),
                           32'($urandom_range(2000000)),
                           32'($signed($urandom_range(200000)) - 250000),
                           32'($urandom_range(250000, 50000)),
                           32'($urandom_range(200000, 1000)));
        test_random(180);

        settle_then_config(32'd655, 32'd655360, 32'd655360, 32'hffff_0000,
                           32'h0001_0000, 32'd32768);
        test_random(150);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/tcvs_pkg.sv
src/two_center_verlet_step.sv
bench/tb.sv
